[design/pip_pkg.sv]
`default_nettype none
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_W = 16;
    localparam int COUNT_OUT_W = 7;
    localparam int DY_W = 18;
    localparam int DX_W = 17;
    localparam int NUM_W = DY_W + DX_W;
    localparam int DEN_W = 17;
    localparam int QUOT_W = NUM_W + 1;
    localparam int CMP_W = QUOT_W + 2;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic REG_X_OFFSET = 1'b0;
    localparam logic REG_Y_OFFSET = 1'b1;

    typedef struct packed {
        logic add_en;
        logic rotate_en;
    } cell_ctl_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_CMP  = 6'b010000,
        S_ROT  = 6'b100000
    } state_t;

endpackage
`default_nettype wire

[design/pip_cell.sv]
`default_nettype none
module pip_cell
    import pip_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  wire                       clk,
    input  cell_ctl_t                 ctl,
    input  wire [CNT_W-1:0]           count,
    input  wire signed [COORD_W-1:0]  load_x,
    input  wire signed [COORD_W-1:0]  load_y,
    input  wire signed [COORD_W-1:0]  next_x,
    input  wire signed [COORD_W-1:0]  next_y,
    input  wire signed [COORD_W-1:0]  head_x,
    input  wire signed [COORD_W-1:0]  head_y,
    output logic signed [COORD_W-1:0] x,
    output logic signed [COORD_W-1:0] y
);

    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic                      in_ring;
    logic                      is_last;

    assign in_ring = CNT_W'(INDEX) < count;
    assign is_last = CNT_W'(INDEX) == (count - CNT_W'(1));

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (ctl.add_en && (count == CNT_W'(INDEX)))
        begin
            x_next = load_x;
            y_next = load_y;
        end
        else if (ctl.rotate_en && in_ring)
        begin
            x_next = is_last ? head_x : next_x;
            y_next = is_last ? head_y : next_y;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule
`default_nettype wire

[design/pip_divider.sv]
`default_nettype none
module pip_divider
    import pip_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire signed [NUM_W-1:0]   num,
    input  wire signed [DEN_W-1:0]   den,
    output logic                     busy,
    output logic                     done,
    output logic signed [QUOT_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  work_reg, work_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    assign trial = {rem_reg, work_reg[NUM_W-1]};
    assign diff = trial - {1'b0, den_reg};

    always_comb
    begin
        work_next = work_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_next = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_next = num[NUM_W-1] ^ den[DEN_W-1];
            rem_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_next = diff[DEN_W-1:0];
                work_next = {work_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                work_next = {work_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, work_reg}) : $signed({1'b0, work_reg});

endmodule
`default_nettype wire

[design/point_in_polygon_test_core.sv]
// add, close and unused kinds: result in the cycle after the request is taken
// query: each stored edge is evaluated in turn by rotating the vertex ring; an edge that straddles
// the query y also goes through the multiply and the bit-serial divider (one quotient bit a cycle)
// throughput: one request at a time; a new request is taken no earlier than the cycle
// in which the previous result is taken
// reset (rst_n low, asynchronous): empty open polygon, offsets zero, no result pending
`default_nettype none
module point_in_polygon_test_core
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire [1:0]                kind,
    input  wire signed [COORD_W-1:0] x_coord,
    input  wire signed [COORD_W-1:0] y_coord,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic                     inside_res,
    output logic                     accepted,
    output logic [COUNT_OUT_W-1:0]   vertex_count,
    input  wire                      cfg_we,
    input  wire                      cfg_addr,
    input  wire [COORD_W-1:0]        cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           edge_reg, edge_next;
    logic                       closed_reg, closed_next;
    logic                       parity_reg, parity_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       inside_reg, inside_next;
    logic                       acc_reg, acc_next;
    logic signed [COORD_W-1:0]  xoff_reg, yoff_reg;
    logic signed [COORD_W-1:0]  px_reg, py_reg;
    logic signed [COORD_W-1:0]  xa_reg;
    logic signed [DY_W-1:0]     dy_reg;
    logic signed [DX_W-1:0]     dx_reg;
    logic signed [DEN_W-1:0]    den_reg;
    logic signed [NUM_W-1:0]    prod_reg;
    logic signed [COORD_W-1:0]  cx [MAX_VERTICES];
    logic signed [COORD_W-1:0]  cy [MAX_VERTICES];
    cell_ctl_t                  ctl;
    logic                       take;
    logic                       div_start, div_busy, div_done;
    logic signed [QUOT_W-1:0]   quot;
    logic signed [COORD_W-1:0]  xb, yb;
    logic signed [DEN_W-1:0]    ya_s, yb_s, py_e;
    logic                       straddle;
    logic signed [CMP_W-1:0]    lhs, rhs;
    logic [31:0]                count32;

    generate
        for (genvar k = 0; k < MAX_VERTICES; k++)
        begin : g_cell
            pip_cell #(
                .INDEX (k),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .count  (count_reg),
                .load_x (x_coord),
                .load_y (y_coord),
                .next_x (cx[(k + 1) % MAX_VERTICES]),
                .next_y (cy[(k + 1) % MAX_VERTICES]),
                .head_x (cx[0]),
                .head_y (cy[0]),
                .x      (cx[k]),
                .y      (cy[k])
            );
        end
    endgenerate

    pip_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign take = in_valid && in_ready;

    assign xb = (count_reg == CNT_W'(1)) ? cx[0] : cx[1];
    assign yb = (count_reg == CNT_W'(1)) ? cy[0] : cy[1];
    assign ya_s = DEN_W'(cy[0]) + DEN_W'(yoff_reg);
    assign yb_s = DEN_W'(yb) + DEN_W'(yoff_reg);
    assign py_e = DEN_W'(py_reg);
    assign straddle = ((ya_s < py_e) && (yb_s >= py_e)) || ((yb_s < py_e) && (ya_s >= py_e));

    assign lhs = CMP_W'(xa_reg) + CMP_W'(quot);
    assign rhs = CMP_W'(px_reg) - CMP_W'(xoff_reg);

    // product is registered on leaving the multiply state
    assign div_start = (state_reg == S_DIV) && !div_busy && !div_done;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        edge_next = edge_reg;
        closed_next = closed_reg;
        parity_next = parity_reg;
        out_valid_next = out_valid_reg && !out_ready;
        inside_next = inside_reg;
        acc_next = acc_reg;
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    inside_next = 1'b0;
                    acc_next = 1'b0;
                    case (kind)
                        KIND_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (!closed_reg && (count_reg < CNT_W'(MAX_VERTICES)))
                            begin
                                ctl.add_en = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                acc_next = 1'b1;
                            end
                        end
                        KIND_CLOSE:
                        begin
                            out_valid_next = 1'b1;
                            closed_next = 1'b1;
                        end
                        KIND_QUERY:
                        begin
                            edge_next = '0;
                            parity_next = 1'b0;
                            state_next = S_EVAL;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_EVAL:
            begin
                if (edge_reg == count_reg)
                begin
                    out_valid_next = 1'b1;
                    inside_next = parity_reg;
                    state_next = S_IDLE;
                end
                else if (straddle)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_ROT;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (lhs < rhs)
                begin
                    parity_next = !parity_reg;
                end
                state_next = S_ROT;
            end
            S_ROT:
            begin
                ctl.rotate_en = 1'b1;
                edge_next = edge_reg + CNT_W'(1);
                state_next = S_EVAL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            edge_reg <= '0;
            closed_reg <= 1'b0;
            parity_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            inside_reg <= 1'b0;
            acc_reg <= 1'b0;
            xoff_reg <= '0;
            yoff_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            edge_reg <= edge_next;
            closed_reg <= closed_next;
            parity_reg <= parity_next;
            out_valid_reg <= out_valid_next;
            inside_reg <= inside_next;
            acc_reg <= acc_next;
            if (cfg_we && (cfg_addr == REG_X_OFFSET))
            begin
                xoff_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == REG_Y_OFFSET))
            begin
                yoff_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
        end
        if (state_reg == S_EVAL)
        begin
            xa_reg <= cx[0];
            dy_reg <= DY_W'(py_reg) - DY_W'(cy[0]) - DY_W'(yoff_reg);
            dx_reg <= DX_W'(xb) - DX_W'(cx[0]);
            den_reg <= DEN_W'(yb) - DEN_W'(cy[0]);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= NUM_W'(dy_reg) * NUM_W'(dx_reg);
        end
    end

    assign count32 = 32'(count_reg);
    assign out_valid = out_valid_reg;
    assign inside_res = inside_reg;
    assign accepted = acc_reg;
    assign vertex_count = count32[COUNT_OUT_W-1:0];

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_reg <= count_reg)
        else $error("edge counter ran past the vertex count");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide state");

    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed polygon reopened");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above capacity");

endmodule
`default_nettype wire

[verif/tb_top.sv]
module tb_top;
    import pip_pkg::*;

    localparam int NVERT = MAX_VERTICES_DEF;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DIRECTED_ROWS = 16;

    typedef struct packed {
        logic        in_poly;
        logic        acc;
        logic [6:0]  count;
    } poly_result_t;

    typedef struct {
        logic [1:0]        kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic              has_exp;
        poly_result_t      exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] kind = KIND_ADD;
    logic signed [15:0] x_coord = '0;
    logic signed [15:0] y_coord = '0;
    logic out_valid;
    logic in_ready;
    logic out_ready = 1'b0;
    logic inside_res;
    logic accepted;
    logic [6:0] vertex_count;
    logic cfg_we = 1'b0;
    logic cfg_addr = REG_X_OFFSET;
    logic [15:0] cfg_wdata = '0;

    longint vx [NVERT];
    longint vy [NVERT];
    int unsigned poly_count;
    bit poly_closed;
    longint xoff, yoff;

    poly_result_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;

    point_in_polygon_test_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .x_coord(x_coord), .y_coord(y_coord),
        .out_valid(out_valid), .out_ready(out_ready),
        .inside_res(inside_res), .accepted(accepted), .vertex_count(vertex_count),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic bit parity_inside(longint px, longint py);
        bit par;
        int unsigned b;
        longint ya, yb, num, den;
        par = 1'b0;
        for (int unsigned a = 0; a < poly_count; a++)
        begin
            b = (a + 1 == poly_count) ? 0 : a + 1;
            ya = vy[a] + yoff;
            yb = vy[b] + yoff;
            if ((ya < py && yb >= py) || (yb < py && ya >= py))
            begin
                den = vy[b] - vy[a];
                if (den != 0)
                begin
                    num = (py - vy[a] - yoff) * (vx[b] - vx[a]);
                    if (vx[a] + num / den < px - xoff)
                        par = ~par;
                end
            end
        end
        return par;
    endfunction

    function automatic poly_result_t apply_request(logic [1:0] k, logic signed [15:0] x,
                                                   logic signed [15:0] y);
        poly_result_t r;
        r = '0;
        if (k == KIND_ADD)
        begin
            if (!poly_closed && poly_count < NVERT)
            begin
                vx[poly_count] = x;
                vy[poly_count] = y;
                poly_count++;
                r.acc = 1'b1;
            end
        end
        else if (k == KIND_CLOSE)
            poly_closed = 1'b1;
        else if (k == KIND_QUERY)
            r.in_poly = parity_inside(x, y);
        r.count = poly_count[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // receiver: stall pattern and checking
    int stall_phase = 0;
    always @(posedge clk)
    begin
        poly_result_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    e = pending_results.pop_front();
                    if (inside_res !== e.in_poly)
                        report_mismatch("inside_res", inside_res, e.in_poly);
                    if (accepted !== e.acc)
                        report_mismatch("accepted", accepted, e.acc);
                    if (vertex_count !== e.count)
                        report_mismatch("vertex_count", vertex_count, e.count);
                end
            end
            stall_phase <= stall_phase + 1;
            if (stall_phase[9])
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[point_in_polygon_test_core] ERROR");
                $finish;
            end
        end
    end

    int burst_left = 0;

    task automatic send_request(logic [1:0] k, logic signed [15:0] x, logic signed [15:0] y,
                                logic has_exp, poly_result_t want);
        poly_result_t r;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        x_coord <= x;
        y_coord <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = apply_request(k, x, y);
        if (has_exp && r !== want)
            report_mismatch("directed row", r, want);
        pending_results.push_back(r);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic a, logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (a == REG_X_OFFSET)
            xoff = longint'($signed(d));
        else
            yoff = longint'($signed(d));
        @(posedge clk);
    endtask

    task automatic clear_poly_model();
        poly_count = 0;
        poly_closed = 1'b0;
    endtask

    stim_row_t dir_rows [DIRECTED_ROWS];
    logic signed [15:0] rx, ry;
    logic [1:0] rk;

    initial
    begin
        clear_poly_model();
        xoff = 0;
        yoff = 0;
        // queries on empty and single vertex answer zero, then a square
        dir_rows[0]  = '{KIND_QUERY, 16'sd0, 16'sd0, 1'b1, '{1'b0, 1'b0, 7'd0}};
        dir_rows[1]  = '{KIND_SPARE, -16'sd1, -16'sd1, 1'b1, '{1'b0, 1'b0, 7'd0}};
        dir_rows[2]  = '{KIND_ADD, -16'sd32768, -16'sd32768, 1'b1, '{1'b0, 1'b1, 7'd1}};
        dir_rows[3]  = '{KIND_QUERY, 16'sd32767, 16'sd32767, 1'b1, '{1'b0, 1'b0, 7'd1}};
        dir_rows[4]  = '{KIND_ADD, 16'sd32767, -16'sd32768, 1'b1, '{1'b0, 1'b1, 7'd2}};
        dir_rows[5]  = '{KIND_QUERY, 16'sd0, 16'sd0, 1'b0, '0};
        dir_rows[6]  = '{KIND_ADD, 16'sd32767, 16'sd32767, 1'b1, '{1'b0, 1'b1, 7'd3}};
        dir_rows[7]  = '{KIND_QUERY, 16'sd100, 16'sd0, 1'b0, '0};
        dir_rows[8]  = '{KIND_ADD, -16'sd32768, 16'sd32767, 1'b1, '{1'b0, 1'b1, 7'd4}};
        dir_rows[9]  = '{KIND_QUERY, 16'sd0, 16'sd0, 1'b0, '0};
        dir_rows[10] = '{KIND_CLOSE, 16'sd5, 16'sd5, 1'b1, '{1'b0, 1'b0, 7'd4}};
        dir_rows[11] = '{KIND_ADD, 16'sd1, 16'sd1, 1'b1, '{1'b0, 1'b0, 7'd4}};
        dir_rows[12] = '{KIND_CLOSE, 16'sd0, 16'sd0, 1'b1, '{1'b0, 1'b0, 7'd4}};
        dir_rows[13] = '{KIND_QUERY, 16'sd32767, 16'sd0, 1'b0, '0};
        dir_rows[14] = '{KIND_QUERY, -16'sd32768, -16'sd32768, 1'b0, '0};
        dir_rows[15] = '{KIND_QUERY, -16'sd5, 16'sd32767, 1'b0, '0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_X_OFFSET, 16'd0);
        write_reg(REG_Y_OFFSET, 16'd0);
        foreach (dir_rows[i])
            send_request(dir_rows[i].kind, dir_rows[i].x, dir_rows[i].y,
                         dir_rows[i].has_exp, dir_rows[i].exp);
        drain_results();
        // polygon cannot be cleared and is already closed, so the random adds are refused; then mostly queries
        write_reg(REG_X_OFFSET, 16'h7fff);
        write_reg(REG_Y_OFFSET, 16'h8000);
        for (int i = 0; i < 60; i++)
        begin
            rk = ($urandom_range(0, 9) == 0) ? KIND_SPARE : KIND_ADD;
            rx = 16'($urandom());
            ry = 16'($urandom());
            send_request(rk, rx, ry, 1'b0, '0);
        end
        for (int i = 0; i < 200; i++)
        begin
            case (i)
                50:  begin drain_results(); write_reg(REG_X_OFFSET, 16'h8000);
                     write_reg(REG_Y_OFFSET, 16'h7fff); end
                100: begin drain_results(); write_reg(REG_X_OFFSET, 16'($urandom()));
                     write_reg(REG_Y_OFFSET, 16'($urandom())); end
                150: begin drain_results(); write_reg(REG_X_OFFSET, 16'd0);
                     write_reg(REG_Y_OFFSET, 16'd0); end
                default: ;
            endcase
            rk = 2'($urandom_range(0, 3));
            if (rk != KIND_QUERY && $urandom_range(0, 2) != 0)
                rk = KIND_QUERY;
            rx = 16'($urandom());
            ry = 16'($urandom());
            send_request(rk, rx, ry, 1'b0, '0);
        end
        drain_results();
        if (errors == 0)
            $display("[point_in_polygon_test_core] OK");
        else
            $display("[point_in_polygon_test_core] ERROR");
        $finish;
    end
endmodule
